FILE: rtl/recursive_median_filter_assert.svh
// Assertion macros shared by the checker of the recursive median filter.
`ifndef RECURSIVE_MEDIAN_FILTER_ASSERT_SVH
`define RECURSIVE_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, switched off while reset is active.
`define RMF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is active.
`define RMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication that also watches the reset itself.
`define RMF_ASSERT_RST(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rmf_pkg.sv
// Package with the types, constants and helper functions of the recursive median filter.
`timescale 1ns / 1ps
`default_nettype none
package rmf_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int MAX_WINDOW   = 19;
	localparam int HALF_MAX     = (MAX_WINDOW - 1) / 2;
	localparam int HALF_W       = $clog2(HALF_MAX + 1);
	localparam int WIDX_W       = $clog2(MAX_WINDOW);
	localparam int RANK_W       = $clog2(MAX_WINDOW + 1);
	localparam int COUNT_W      = 5;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef sample_t                        window_t [MAX_WINDOW];
	typedef logic [HALF_W-1:0]              half_t;
	typedef logic [COUNT_W-1:0]             count_t;
	typedef logic [1:0]                     wsel_t;

	localparam count_t COUNT_MAX = '1;

	// Window select codes.
	localparam wsel_t WSEL_5PT  = 2'd0;
	localparam wsel_t WSEL_9PT  = 2'd1;
	localparam wsel_t WSEL_19PT = 2'd2;

	// One input item as held in the input register.
	typedef struct packed {
		logic    valid;
		sample_t sample;
		logic    frame_end;
	} item_t;

	// One result item.
	typedef struct packed {
		sample_t value;
		logic    last;
	} result_t;

	// Half-width of the window for a select code, clamped to the store size.
	function automatic half_t half_width(input wsel_t sel);
		int hv;
		unique case (sel)
			WSEL_5PT: hv = 2;
			WSEL_9PT: hv = 4;
			default:  hv = 9;
		endcase
		if (hv > HALF_MAX) begin
			hv = HALF_MAX;
		end
		return half_t'(hv);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rmf_channels.sv
// Valid/ready channel interfaces for the input and result items.
`timescale 1ns / 1ps
`default_nettype none
interface rmf_in_if import rmf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface rmf_out_if import rmf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t value;
	logic    last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/rmf_median.sv
// Rank-compare median over the first 2H+1 entries of the window.
`timescale 1ns / 1ps
`default_nettype none
module rmf_median import rmf_pkg::*; (
	input  window_t wnd,
	input  half_t   h,
	output sample_t med
);

	logic [RANK_W-1:0] rank [MAX_WINDOW];

	// Stable rank of every entry among the active entries.
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MAX_WINDOW; j++) begin
				if ((j <= 2 * int'(h)) &&
				    ((wnd[j] < wnd[i]) || ((wnd[j] == wnd[i]) && (j < i)))) begin
					rank[i] = rank[i] + 1'b1;
				end
			end
		end
	end

	// Exactly one active entry has rank H; pick it.
	always_comb begin
		med = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if ((i <= 2 * int'(h)) && (rank[i] == RANK_W'(h))) begin
				med = med | wnd[i];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/rmf_core.sv
// Window store, position counter, frame-end flush and result register.
`timescale 1ns / 1ps
`default_nettype none
module rmf_core import rmf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  wsel_t   window_select,
	input  item_t   item_s1,
	output logic    take,
	output result_t result_q,
	output logic    result_valid_q,
	input  logic    result_ready
);

	window_t           wnd_q;
	window_t           wnd_shift;
	window_t           wnd_next;
	count_t            count_q;
	logic              flush_q;
	half_t             flush_idx_q;
	half_t             h;
	half_t             d;
	logic [WIDX_W-1:0] hidx;
	logic [WIDX_W-1:0] didx;
	sample_t           med;
	logic              out_free;
	logic              q_ge_h;
	logic              q_ge_2h;
	logic              do_filter;
	logic              emit;
	result_t           emit_res;

	rmf_median u_median (
		.wnd (wnd_shift),
		.h   (h),
		.med (med)
	);

	// Handshake toward the input register.
	always_comb begin
		out_free = !result_valid_q || result_ready;
		take     = item_s1.valid && !flush_q && out_free;
	end

	// Window after shifting in the new sample, with the median written back when do_filter is set.
	always_comb begin
		h       = half_width(window_select);
		hidx    = WIDX_W'(h);
		q_ge_h  = int'(count_q) >= int'(h);
		q_ge_2h = int'(count_q) >= 2 * int'(h);
		d       = q_ge_h ? h : half_t'(count_q);
		didx    = WIDX_W'(d);
		wnd_shift[0] = item_s1.sample;
		for (int k = 1; k < MAX_WINDOW; k++) begin
			wnd_shift[k] = wnd_q[k-1];
		end
		if (item_s1.frame_end) begin
			do_filter = q_ge_2h && (window_select == WSEL_5PT);
		end else begin
			do_filter = q_ge_2h;
		end
		wnd_next = wnd_shift;
		if (do_filter) begin
			wnd_next[hidx] = med;
		end
	end

	// Result selection: a flush step, the oldest entry of a frame end, or position q-H.
	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		if (flush_q) begin
			if (out_free) begin
				emit           = 1'b1;
				emit_res.value = wnd_q[WIDX_W'(flush_idx_q)];
				emit_res.last  = (flush_idx_q == '0);
			end
		end else if (take) begin
			if (item_s1.frame_end) begin
				emit           = 1'b1;
				emit_res.value = wnd_next[didx];
				emit_res.last  = (d == '0);
			end else if (q_ge_h) begin
				emit           = 1'b1;
				emit_res.value = wnd_next[hidx];
				emit_res.last  = 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= emit_res;
		end
	end

	// Window store, position counter and flush sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_WINDOW; k++) begin
				wnd_q[k] <= '0;
			end
			count_q     <= '0;
			flush_q     <= 1'b0;
			flush_idx_q <= '0;
		end else if (flush_q) begin
			if (out_free) begin
				if (flush_idx_q == '0) begin
					flush_q <= 1'b0;
					for (int k = 0; k < MAX_WINDOW; k++) begin
						wnd_q[k] <= '0;
					end
				end else begin
					flush_idx_q <= flush_idx_q - 1'b1;
				end
			end
		end else if (take) begin
			if (item_s1.frame_end) begin
				count_q <= '0;
				if (d == '0) begin
					for (int k = 0; k < MAX_WINDOW; k++) begin
						wnd_q[k] <= '0;
					end
				end else begin
					wnd_q       <= wnd_next;
					flush_q     <= 1'b1;
					flush_idx_q <= d - 1'b1;
				end
			end else begin
				wnd_q <= wnd_next;
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/recursive_median_filter.sv
// Top level of the recursive median filter: input register, config register and core.
//
// Usage:
//   in_ch carries one profile sample per item with frame_end on the last sample of a
//   frame; out_ch carries the filtered samples in frame order with last on the final
//   one. Both use valid/ready; an item moves when both are high at a clock edge.
//   cfg_wr_en/cfg_wr_data write window_select (0: 5, 1: 9, 2 or 3: 19 points); write
//   it only between frames while the block is idle.
//   Throughput is one item per cycle when out_ch does not stall and no flush runs.
//   The result for position i is loaded into the output register at the edge that
//   takes the item for position i+H from the input register. The median is a
//   combinational rank compare over the 2H+1 window taps, fed back into the
//   window in the same cycle.
//   A frame-end item emits up to H+1 results, one per cycle unless out_ch stalls;
//   meanwhile the input register holds one further item and in_ch.ready stays low.
//   When out_ch stalls the result register holds its item and the input register
//   absorbs one more item before in_ch.ready drops.
//   Reset clears the window, the position counter, all valid flags and sets the
//   5-point mode.
`timescale 1ns / 1ps
`default_nettype none
module recursive_median_filter import rmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rmf_in_if.sink      in_ch,
	rmf_out_if.source   out_ch,
	input  logic        cfg_wr_en,
	input  wsel_t       cfg_wr_data
);

	item_t   item_s1;
	wsel_t   wsel_q;
	logic    take;
	result_t result_q;
	logic    result_valid_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= WSEL_5PT;
		end else if (cfg_wr_en) begin
			wsel_q <= cfg_wr_data;
		end
	end

	// Input register; it frees up in the same cycle the core takes its item.
	assign in_ch.ready = !item_s1.valid || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_ch.valid && in_ch.ready) begin
			item_s1 <= '{valid: 1'b1, sample: in_ch.sample, frame_end: in_ch.frame_end};
		end else if (take) begin
			item_s1.valid <= 1'b0;
		end
	end

	rmf_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_select  (wsel_q),
		.item_s1        (item_s1),
		.take           (take),
		.result_q       (result_q),
		.result_valid_q (result_valid_q),
		.result_ready   (out_ch.ready)
	);

	// Output channel straight from the result register.
	assign out_ch.valid = result_valid_q;
	assign out_ch.value = result_q.value;
	assign out_ch.last  = result_q.last;

endmodule
`default_nettype wire

FILE: rtl/rmf_checker.sv
// Port-level checker for the recursive median filter and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "recursive_median_filter_assert.svh"
module rmf_checker import rmf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input sample_t out_value,
	input logic    out_last
);

	// A stalled result holds its item.
	`RMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last), "stalled result item changed")

	// The input side only blocks while a result item waits or a flush drains into it.
	`RMF_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty result register")

	// Leaving reset, nothing is pending and the input is open.
	`RMF_ASSERT_RST(a_reset_clean, $rose(arst_n), !out_valid && in_ready, "state not clear after reset")

endmodule

bind recursive_median_filter rmf_checker u_rmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_value (out_ch.value),
	.out_last  (out_ch.last)
);
`default_nettype wire
